// File: rtl/char_lcd_nibble_writer_top_defines.svh
// Assertion macros for the character LCD nibble writer.
// Used by char_lcd_nibble_writer_top; expects aclk and aresetn in scope.
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLNW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLNW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/clnw_pkg.sv
// Shared types, constants and microcode ROM for the character LCD nibble writer.
// No dependencies.
package clnw_pkg;

    localparam int NUMBER_BITS = 32;
    // decimal digits of 2^NUMBER_BITS - 1: floor(N * log10(2)) + 1
    localparam int DEC_DIGITS  = ((NUMBER_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS    = DEC_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(NUMBER_BITS + 1);
    localparam int DIG_CNT_W   = $clog2(DEC_DIGITS + 1);
    localparam int STEP_W      = 4;

    localparam logic [7:0] ROW1_BASE    = 8'h40;
    localparam logic [7:0] SET_ADDR_CMD = 8'h80;
    localparam logic [7:0] CLEAR_CMD    = 8'h01;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [2:0] {
        REQ_CMD    = 3'd0,
        REQ_DATA   = 3'd1,
        REQ_CURSOR = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_NUMBER = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_BYTE,
        MODE_NUM
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DABBLE,
        ACT_PICK,
        ACT_EMIT_HI,
        ACT_EMIT_LO
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NOT_ACCEPT,
        C_MODE_BYTE,
        C_MODE_NONE,
        C_BITS_LEFT,
        C_SKIP_ZERO,
        C_OUT_BUSY,
        C_MORE_DIGITS
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ucw_t;

    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_ISBYTE = 4'd1;
    localparam step_t S_ISNONE = 4'd2;
    localparam step_t S_DABBLE = 4'd3;
    localparam step_t S_PICK   = 4'd4;
    localparam step_t S_HI     = 4'd5;
    localparam step_t S_LO     = 4'd6;
    localparam step_t S_MORE   = 4'd7;
    localparam step_t S_DONE   = 4'd8;

    // Jump to target when cond holds, else fall through to the next step.
    function automatic ucw_t ucode(step_t s);
        ucw_t w;
        begin
            unique case (s)
                S_IDLE:   w = '{ACT_LOAD,    C_NOT_ACCEPT,  S_IDLE};
                S_ISBYTE: w = '{ACT_NONE,    C_MODE_BYTE,   S_HI};
                S_ISNONE: w = '{ACT_NONE,    C_MODE_NONE,   S_IDLE};
                S_DABBLE: w = '{ACT_DABBLE,  C_BITS_LEFT,   S_DABBLE};
                S_PICK:   w = '{ACT_PICK,    C_SKIP_ZERO,   S_PICK};
                S_HI:     w = '{ACT_EMIT_HI, C_OUT_BUSY,    S_HI};
                S_LO:     w = '{ACT_EMIT_LO, C_OUT_BUSY,    S_LO};
                S_MORE:   w = '{ACT_NONE,    C_MORE_DIGITS, S_PICK};
                S_DONE:   w = '{ACT_NONE,    C_ALWAYS,      S_IDLE};
                default:  w = '{ACT_NONE,    C_ALWAYS,      S_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// File: rtl/char_lcd_nibble_writer_top.sv
// Character LCD nibble writer: display requests in, 4-bit LCD transfers out.
// Depends on clnw_pkg and char_lcd_nibble_writer_top_defines.svh.
//
//  channel | dir | tdata                                     | tuser      | tlast
//  s_      | in  | byte_value, cursor_row, cursor_col, number | req_type   | -
//  m_      | out | nibble (+4 pad bits)                      | reg_select | last
//
// One request at a time, run by a 9-step microcode program.
// Byte-type requests emit a high and a low nibble; dropped requests emit none.
// Print number: the 32-step shift-add-3 conversion, then one step per digit
// position, with a high and a low nibble for each digit printed.
// Output stalls hold the program at the emit steps. Sync active-low reset.
`include "char_lcd_nibble_writer_top_defines.svh"

module char_lcd_nibble_writer_top import clnw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] byte_value, [9:8] cursor_row, [15:10] cursor_col, [47:16] number_value
    input  logic [47:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] nibble, [7:4] zero
    output logic [7:0]  m_tdata,
    // [0] reg_select
    output logic        m_tuser,
    output logic        m_tlast
);

    step_t                  step_reg, step_next;
    mode_t                  mode_reg, mode_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   rs_reg, rs_next;
    logic                   last_reg, last_next;
    logic [NUMBER_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]    bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   started_reg, started_next;
    logic                   m_valid_reg, m_valid_next;
    logic [3:0]             m_nib_reg, m_nib_next;
    logic                   m_rs_reg, m_rs_next;
    logic                   m_last_reg, m_last_next;

    ucw_t                   uw;
    logic                   accept;
    logic                   out_free;
    logic                   cond_hit;
    logic [3:0]             digit;
    logic                   final_digit;
    logic [BCD_BITS-1:0]    bcd_adj;
    logic [7:0]             cursor_cmd;
    logic [1:0]             row;
    logic [5:0]             col;

    assign uw          = ucode(step_reg);
    assign s_tready    = (step_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign digit       = bcd_reg[BCD_BITS-1 -: 4];
    assign final_digit = (dig_cnt_reg == DIG_CNT_W'(DEC_DIGITS - 1));
    assign row         = s_tdata[9:8];
    assign col         = s_tdata[15:10];
    assign cursor_cmd  = (row == 2'd0) ? (SET_ADDR_CMD | {2'b00, col})
                                       : (SET_ADDR_CMD | (ROW1_BASE + {2'b00, col}));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_nib_reg};
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                             : bcd_reg[i*4 +: 4];
        end
    end

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:      cond_hit = 1'b1;
            C_NOT_ACCEPT:  cond_hit = !accept;
            C_MODE_BYTE:   cond_hit = (mode_reg == MODE_BYTE);
            C_MODE_NONE:   cond_hit = (mode_reg == MODE_NONE);
            C_BITS_LEFT:   cond_hit = (bit_cnt_reg != BIT_CNT_W'(NUMBER_BITS - 1));
            C_SKIP_ZERO:   cond_hit = (digit == 4'd0) && !started_reg && !final_digit;
            C_OUT_BUSY:    cond_hit = !out_free;
            C_MORE_DIGITS: cond_hit = (mode_reg == MODE_NUM)
                                      && (dig_cnt_reg != DIG_CNT_W'(DEC_DIGITS));
            default:       cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? uw.target : step_reg + step_t'(1);
    end

    always_comb begin
        mode_next    = mode_reg;
        byte_next    = byte_reg;
        rs_next      = rs_reg;
        last_next    = last_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_nib_next   = m_nib_reg;
        m_rs_next    = m_rs_reg;
        m_last_next  = m_last_reg;

        unique case (uw.act)
            ACT_NONE: begin
            end
            ACT_LOAD: begin
                if (accept) begin
                    mode_next    = MODE_BYTE;
                    last_next    = 1'b1;
                    rs_next      = RS_CMD;
                    byte_next    = s_tdata[7:0];
                    // number taken in its low NUMBER_BITS bits
                    bin_next     = NUMBER_BITS'(s_tdata[47:16]);
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = '0;
                    started_next = 1'b0;
                    unique case (s_tuser)
                        REQ_CMD: begin
                        end
                        REQ_DATA:   rs_next = RS_DATA;
                        REQ_CURSOR: begin
                            byte_next = cursor_cmd;
                            if (row[1]) mode_next = MODE_NONE;
                        end
                        REQ_CLEAR:  byte_next = CLEAR_CMD;
                        REQ_NUMBER: begin
                            mode_next = MODE_NUM;
                            rs_next   = RS_DATA;
                            last_next = 1'b0;
                        end
                        default:    mode_next = MODE_NONE;
                    endcase
                end
            end
            ACT_DABBLE: begin
                bcd_next     = {bcd_adj[BCD_BITS-2:0], bin_reg[NUMBER_BITS-1]};
                bin_next     = {bin_reg[NUMBER_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            end
            ACT_PICK: begin
                byte_next    = ASCII_ZERO | {4'b0000, digit};
                bcd_next     = {bcd_reg[BCD_BITS-5:0], 4'b0000};
                dig_cnt_next = dig_cnt_reg + DIG_CNT_W'(1);
                last_next    = final_digit;
                started_next = started_reg || (digit != 4'd0);
            end
            ACT_EMIT_HI: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_nib_next   = byte_reg[7:4];
                    m_rs_next    = rs_reg;
                    m_last_next  = 1'b0;
                end
            end
            ACT_EMIT_LO: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_nib_next   = byte_reg[3:0];
                    m_rs_next    = rs_reg;
                    m_last_next  = last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= S_IDLE;
            mode_reg    <= MODE_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        rs_reg      <= rs_next;
        last_reg    <= last_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        started_reg <= started_next;
        m_nib_reg   <= m_nib_next;
        m_rs_reg    <= m_rs_next;
        m_last_reg  <= m_last_next;
    end

    `CLNW_ASSERT_NEXT(a_no_emit_in_conv, step_reg == S_DABBLE, !$rose(m_valid_reg), "transfer during conversion")
    `CLNW_ASSERT_NEXT(a_final_digit_last, step_reg == S_PICK && final_digit, last_reg, "final digit not marked last")
    `CLNW_ASSERT_NOW(a_ready_idle_only, s_tready, m_valid_reg == 1'b0 || step_reg == S_IDLE, "ready outside idle")

endmodule
